// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL; causal_moving_average.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Hold a condition on every enabled clock edge.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// Require the consequent in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Require the consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/cma_pkg.sv -----
// Shared types and constants of the moving-average filter.
`timescale 1ns / 1ps

package cma_pkg;

    localparam int WIN_LEN_W = 5;
    localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 5'd3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- hw/rtl/cma_if.sv -----
// Request channel interfaces for samples in and averages out.
`timescale 1ns / 1ps

interface cma_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in_series;

    modport source (output valid, output sample, output last_in_series, input ready);
    modport sink   (input valid, input sample, input last_in_series, output ready);
endinterface

interface cma_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          series_end;

    modport source (output valid, output average, output series_end, input ready);
    modport sink   (input valid, input average, input series_end, output ready);
endinterface

// ----- hw/rtl/cma_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module cma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/cma_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module cma_div
    import cma_pkg::*;
#(
    parameter int DW = 20,
    parameter int VW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_ctrl     i_ctrl,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output t_div_stat     o_stat,
    output logic [DW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    r_q;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_d;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [VW:0] trial;
    logic        ge;

    // Shift in the next dividend bit and try one subtract.
    assign trial = {r_rem, r_q[DW-1]};
    assign ge    = (trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], ge};
            r_rem <= ge ? VW'(trial - {1'b0, r_d}) : VW'(trial);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_q;

endmodule

// ----- hw/rtl/causal_moving_average.sv -----
// Causal moving average of signed fixed-point samples over a growing window.
// Each accepted sample is summed with the older ones in the window in use, one history read
// per cycle, into SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW) bits, then divided by the
// one-bit-per-cycle divider; a stalled output register holds the result back in S_HOLD. A new
// sample is accepted only in S_IDLE, once the previous result has entered the output register.
// Reset is synchronous, active low.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module causal_moving_average
    import cma_pkg::*;
#(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [WIN_LEN_W-1:0] i_cfg_data,
    cma_in_if.sink               i_in,
    cma_out_if.source            o_out
);

    // Pointer, count and accumulator widths.
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int LW    = (CW > WIN_LEN_W) ? CW : WIN_LEN_W;

    // Clamp limits of the quotient magnitude.
    localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'(1) << (SAMPLE_BITS - 1);
    localparam logic [SUM_W-1:0] POS_LIM = NEG_LIM - SUM_W'(1);

    // Control state.
    t_state                r_state, n_state;
    logic [WIN_LEN_W-1:0]  r_window_len;
    logic [CW-1:0]         r_fill, n_fill;
    logic [AW-1:0]         r_wp, n_wp;
    logic [AW-1:0]         r_rd, n_rd;
    logic [CW-1:0]         r_left, n_left;
    logic                  r_pend, n_pend;
    logic                  r_out_valid, n_out_valid;

    // Payload state.
    logic [CW-1:0]           r_n, n_n;
    logic signed [SUM_W-1:0] r_acc, n_acc;
    logic                    r_last, n_last;
    logic [SAMPLE_BITS-1:0]  r_avg, n_avg;
    logic                    r_end, n_end;

    // Datapath helpers.
    logic                   in_fire;
    logic                   out_free;
    logic [LW-1:0]          wl_ext;
    logic [CW-1:0]          w_eff;
    logic [CW-1:0]          fill_next;
    logic [CW-1:0]          n_eff;
    logic [AW-1:0]          wp_next;
    logic [AW-1:0]          rd_start;
    logic [AW-1:0]          rd_dec;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [SUM_W-1:0]       mag;
    logic [SUM_W-1:0]       dividend;
    logic [SUM_W-1:0]       quotient;
    logic [SUM_W-1:0]       neg_q;
    logic [SAMPLE_BITS-1:0] result;
    t_div_ctrl              div_ctrl;
    t_div_stat              div_stat;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // Window in use: zero acts as one, anything past the depth saturates.
    assign wl_ext = LW'(r_window_len);
    always_comb begin
        if (r_window_len == '0) begin
            w_eff = CW'(1);
        end else if (wl_ext > LW'(MAX_WINDOW)) begin
            w_eff = CW'(MAX_WINDOW);
        end else begin
            w_eff = CW'(wl_ext);
        end
    end

    // Count the new sample, saturating at the depth; average the last n of them.
    assign fill_next = (r_fill < CW'(MAX_WINDOW)) ? r_fill + 1'b1 : r_fill;
    assign n_eff     = (fill_next < w_eff) ? fill_next : w_eff;

    // Ring pointers wrap at the depth, which need not be a power of two.
    assign wp_next  = (r_wp == AW'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
    assign rd_start = (r_wp == '0) ? AW'(MAX_WINDOW - 1) : r_wp - 1'b1;
    assign rd_dec   = (r_rd == '0) ? AW'(MAX_WINDOW - 1) : r_rd - 1'b1;

    // Round to nearest, ties away from zero: divide |sum| + n/2 and restore the sign.
    assign mag      = r_acc[SUM_W-1] ? SUM_W'(-r_acc) : SUM_W'(r_acc);
    assign dividend = mag + SUM_W'(r_n >> 1);

    assign div_ctrl.start = (r_state == S_SUM) && (r_left == '0) && !r_pend;

    // Clamp the signed quotient to the sample range.
    assign neg_q = SUM_W'(0) - quotient;
    always_comb begin
        if (r_acc[SUM_W-1]) begin
            result = (quotient > NEG_LIM) ? SAMPLE_BITS'(NEG_LIM) : neg_q[SAMPLE_BITS-1:0];
        end else begin
            result = (quotient > POS_LIM) ? SAMPLE_BITS'(POS_LIM) : quotient[SAMPLE_BITS-1:0];
        end
    end

    // Sample history: write on accept, read backwards from the sample before the newest while summing.
    cma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (in_fire),
        .i_addr  (in_fire ? r_wp : r_rd),
        .i_wdata (i_in.sample),
        .o_rdata (ram_rdata)
    );

    cma_div #(
        .DW (SUM_W),
        .VW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_dividend (dividend),
        .i_divisor  (r_n),
        .o_stat     (div_stat),
        .o_quotient (quotient)
    );

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_wp        = r_wp;
        n_rd        = r_rd;
        n_left      = r_left;
        n_pend      = r_pend;
        n_n         = r_n;
        n_acc       = r_acc;
        n_last      = r_last;
        n_avg       = r_avg;
        n_end       = r_end;
        n_out_valid = r_out_valid;

        // Drop the result once the sink takes it.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    // The new sample seeds the sum; the n - 1 older ones follow.
                    n_acc   = SUM_W'(i_in.sample);
                    n_n     = n_eff;
                    n_left  = n_eff - 1'b1;
                    n_rd    = rd_start;
                    n_pend  = 1'b0;
                    n_last  = i_in.last_in_series;
                    // End of series: clear history count and pointer now.
                    n_fill  = i_in.last_in_series ? '0 : fill_next;
                    n_wp    = i_in.last_in_series ? '0 : wp_next;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                // Issue one read per cycle, add its data in the next cycle.
                if (r_left != '0) begin
                    n_rd   = rd_dec;
                    n_left = r_left - 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    n_acc = r_acc + SUM_W'(signed'(ram_rdata));
                end
                if (div_ctrl.start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    if (out_free) begin
                        n_avg       = result;
                        n_end       = r_last;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                // Hold the quotient until the output register frees up.
                if (out_free) begin
                    n_avg       = result;
                    n_end       = r_last;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window_len <= WIN_LEN_RESET;
            r_fill       <= '0;
            r_wp         <= '0;
            r_rd         <= '0;
            r_left       <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_wp        <= n_wp;
            r_rd        <= n_rd;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_window_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_acc  <= n_acc;
        r_last <= n_last;
        r_avg  <= n_avg;
        r_end  <= n_end;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.average    = r_avg;
    assign o_out.series_end = r_end;

    // An accepted request always starts the summing pass.
    `ASSERT_NEXT(a_accept_sums, i_clk, i_rst_n, in_fire, r_state == S_SUM)
    // The divisor is never zero while the sum is built.
    `ASSERT_IMPLIES(a_n_nonzero, i_clk, i_rst_n, r_state == S_SUM, r_n != '0)
    // The divider finishes only while the sequencer waits on it.
    `ASSERT_IMPLIES(a_div_done, i_clk, i_rst_n, div_stat.done, r_state == S_DIV)
    // The divider runs only while the sequencer waits on it.
    `ASSERT_IMPLIES(a_div_busy, i_clk, i_rst_n, div_stat.busy, r_state == S_DIV)
    // The fill count saturates at the history depth.
    `ASSERT_ALWAYS(a_fill_max, i_clk, i_rst_n, r_fill <= CW'(MAX_WINDOW))

endmodule

// ----- tb/cma_average_checker.sv -----
// Predicts each moving average from the accepted sample requests and compares the results.
`timescale 1ns / 1ps

module cma_average_checker
    import cma_pkg::*;
#(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [WIN_LEN_W-1:0]          i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last_in_series,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_average,
    input  logic                          i_series_end,
    output int                            o_pending,
    output int                            o_fail_count
);

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic                          series_end;
    } t_avg_result;

    logic signed [SAMPLE_BITS-1:0] history [MAX_WINDOW];
    logic [CNT_W-1:0]              fill_count;
    logic [PTR_W-1:0]              wr_ptr;
    logic [WIN_LEN_W-1:0]          window_len;

    t_avg_result averages_due [$];
    t_avg_result due;
    int          fails;

    // Insert one sample into the history and return the average it yields.
    function automatic t_avg_result predict_average(input logic signed [SAMPLE_BITS-1:0] x,
                                                    input logic last);
        int          span;
        int          used;
        int          idx;
        int          k;
        longint      acc;
        longint      mag;
        longint      quot;
        longint      hi;
        longint      lo;
        t_avg_result r;
        span = int'(window_len);
        if (span == 0) begin
            span = 1;
        end
        if (span > MAX_WINDOW) begin
            span = MAX_WINDOW;
        end
        history[wr_ptr] = x;
        wr_ptr = PTR_W'((int'(wr_ptr) + 1) % MAX_WINDOW);
        if (int'(fill_count) < MAX_WINDOW) begin
            fill_count = fill_count + 1'b1;
        end
        used = (int'(fill_count) < span) ? int'(fill_count) : span;
        acc = 0;
        for (k = 0; k < used; k++) begin
            idx = (int'(wr_ptr) + MAX_WINDOW - 1 - k) % MAX_WINDOW;
            acc += longint'(history[idx]);
        end
        // Round half away from zero on the magnitude, then restore the sign.
        mag  = (acc < 0) ? -acc : acc;
        quot = (mag + longint'(used / 2)) / longint'(used);
        acc  = (acc < 0) ? -quot : quot;
        hi   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lo   = -hi - 1;
        if (acc > hi) begin
            acc = hi;
        end
        if (acc < lo) begin
            acc = lo;
        end
        r.average    = acc[SAMPLE_BITS-1:0];
        r.series_end = last;
        if (last) begin
            fill_count = '0;
            wr_ptr     = '0;
        end
        return r;
    endfunction

    task automatic report_failure(input string msg);
        fails++;
        if (fails <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_count = '0;
            wr_ptr     = '0;
            window_len = WIN_LEN_RESET;
            fails      = 0;
            averages_due.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (averages_due.size() == 0) begin
                    report_failure($sformatf("unexpected result: average %0d series_end %0b",
                                             i_average, i_series_end));
                end else begin
                    due = averages_due.pop_front();
                    if (due.average !== i_average || due.series_end !== i_series_end) begin
                        report_failure($sformatf(
                            "mismatch: expected average %0d series_end %0b, got %0d %0b",
                            due.average, due.series_end, i_average, i_series_end));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                averages_due.push_back(predict_average(i_sample, i_last_in_series));
            end
            if (i_cfg_we) begin
                window_len = i_cfg_data;
            end
            o_pending    <= averages_due.size();
            o_fail_count <= fails;
        end
    end

endmodule

// ----- tb/causal_moving_average_tb.sv -----
// Top of the moving-average regression: clock, reset, sample stimulus, window writes, verdict.
`timescale 1ns / 1ps

module causal_moving_average_tb
    import cma_pkg::*;
();

    localparam int MAX_WINDOW  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 9;
    // Worst-case latency is a full window read plus the serial divide; add margin.
    localparam int SETTLE_CYCLES = MAX_WINDOW + SAMPLE_BITS + $clog2(MAX_WINDOW) + 3 + 8;
    // Longest stretch with no request moving on either channel before giving up.
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES = 4;
    localparam int BLOCKS_PER_PHASE = 5;
    localparam int ITEMS_PER_BLOCK = 70;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

    // Kinds of sample content that one random series is built from.
    typedef enum int {
        MIX_FULL,
        MIX_EXTREME,
        MIX_SMALL,
        MIX_RAIL
    } t_mix;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [WIN_LEN_W-1:0] i_cfg_data;

    cma_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    cma_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) average_ch ();

    int pending;
    int fail_count;
    int quiet_cycles = 0;
    int send_idle_pct;
    int recv_stall_pct;

    // Random series state lives across blocks so window writes land mid-series.
    int   series_left;
    t_mix series_mix;
    logic rail_high;

    int send_idle_by_phase [PHASES] = '{0, 54, 0, 16};
    int recv_stall_by_phase [PHASES] = '{0, 0, 54, 16};

    causal_moving_average #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (sample_ch),
        .o_out     (average_ch)
    );

    cma_average_checker #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) avg_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (sample_ch.valid),
        .i_in_ready      (sample_ch.ready),
        .i_sample        (sample_ch.sample),
        .i_last_in_series(sample_ch.last_in_series),
        .i_out_valid     (average_ch.valid),
        .i_out_ready     (average_ch.ready),
        .i_average       (average_ch.average),
        .i_series_end    (average_ch.series_end),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver side: drop ready at random at the rate the current phase asks.
    always @(posedge i_clk) begin
        average_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: count cycles in which no request moves on either channel.
    always @(posedge i_clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (average_ch.valid && average_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one sample request, idling first at the phase's rate, and hold it until taken.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.sample         <= value;
        sample_ch.last_in_series <= last;
        do begin
            @(posedge i_clk);
        end while (!sample_ch.ready);
    endtask

    // Hold off the sender until every predicted average has come back, then let the
    // block settle so a window write finds it idle.
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WIN_LEN_W-1:0] len);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Stream random series: mostly full-range samples, with runs of rail values,
    // extremes and small values near zero to exercise the sum limits and rounding.
    task automatic run_random(input int count);
        int                            i;
        int                            pick;
        logic signed [SAMPLE_BITS-1:0] value;
        for (i = 0; i < count; i++) begin
            if (series_left == 0) begin
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    series_mix = MIX_FULL;
                end else if (pick < 7) begin
                    series_mix = MIX_EXTREME;
                end else if (pick < 9) begin
                    series_mix = MIX_SMALL;
                end else begin
                    series_mix = MIX_RAIL;
                end
                // Mix single-sample series with ones long enough to fill the history.
                series_left = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
                rail_high   = 1'($urandom_range(0, 1));
            end
            case (series_mix)
                MIX_FULL: begin
                    value = SAMPLE_BITS'($urandom);
                end
                MIX_EXTREME: begin
                    case ($urandom_range(0, 4))
                        0: value = SAMPLE_MAX;
                        1: value = SAMPLE_MIN;
                        2: value = '0;
                        3: value = 16'sd1;
                        default: value = -16'sd1;
                    endcase
                end
                MIX_SMALL: begin
                    value = SAMPLE_BITS'($urandom_range(0, 16)) - 16'sd8;
                end
                default: begin
                    value = rail_high ? SAMPLE_MAX : SAMPLE_MIN;
                end
            endcase
            series_left--;
            send_sample(value, series_left == 0);
        end
    endtask

    initial begin
        int phase;
        int blk;
        logic [WIN_LEN_W-1:0] len;

        // Drive every input to a known value before the first edge.
        i_rst_n                  <= 1'b0;
        i_cfg_we                 <= 1'b0;
        i_cfg_data               <= '0;
        sample_ch.valid          <= 1'b0;
        sample_ch.sample         <= '0;
        sample_ch.last_in_series <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        series_left    = 0;
        series_mix     = MIX_FULL;
        rail_high      = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset window of three: saturate the sum at both rails, sliding across the change.
        repeat (3) send_sample(SAMPLE_MAX, 1'b0);
        repeat (3) send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);

        // Window zero behaves as one.
        write_window(5'd0);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'sd5, 1'b1);

        // Window two: ties round away from zero on both signs.
        write_window(5'd2);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(-16'sd4, 1'b0);
        send_sample(-16'sd1, 1'b1);

        // Window above the history depth saturates; the series also ends here.
        write_window(5'd31);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'sd1, 1'b1);

        // Shrink the window in the middle of a series.
        write_window(5'd16);
        send_sample(16'sd10, 1'b0);
        send_sample(16'sd20, 1'b0);
        send_sample(16'sd30, 1'b0);
        send_sample(16'sd41, 1'b0);
        write_window(5'd2);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd8, 1'b1);

        // Random phases, each with its own idle/stall mix and a window write per block.
        for (phase = 0; phase < PHASES; phase++) begin
            send_idle_pct  = send_idle_by_phase[phase];
            recv_stall_pct = recv_stall_by_phase[phase];
            for (blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
                case (blk)
                    0: len = 5'd1;
                    1: len = WIN_LEN_W'(MAX_WINDOW);
                    2: len = 5'd0;
                    3: len = 5'd31;
                    default: len = WIN_LEN_W'($urandom_range(0, 31));
                endcase
                write_window(len);
                run_random(ITEMS_PER_BLOCK);
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
